/* rtl/dsed_pkg.sv */
// Shared types, constants and register codes of the scale-space extremum detector.
`timescale 1ns / 1ps
package dsed_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT      = 4096;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 15;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	// Three window rows (index 0 is the oldest row) or three levels.
	typedef sample_t [2:0] trio_t;
	typedef trio_t [2:0] plane_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_BORDER_WIDTH   = 3'd2,
		REG_CONTRAST_THRES = 3'd3,
		REG_EDGE_RATIO     = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_MAX  = 2'd1,
		KIND_MIN  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_DONE
	} state_t;

	typedef struct packed {
		sample_t lower_sample;
		sample_t center_sample;
		sample_t upper_sample;
	} pixel_t;

	typedef struct packed {
		logic        out_valid;
		logic [9:0]  pos_x;
		logic [11:0] pos_y;
		logic [1:0]  extremum_kind;
		sample_t     center_value;
	} result_t;

endpackage

/* rtl/dsed_line_mem.sv */
// Line buffer memory: one entry per column holding two rows of all three levels.
`timescale 1ns / 1ps
module dsed_line_mem #(
	parameter int DEPTH = dsed_pkg::DEF_MAX_WIDTH,
	parameter int WIDTH = 6 * dsed_pkg::SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/dsed_window.sv */
// 3x3x3 window registers and the max/min test of the window center.
`timescale 1ns / 1ps
module dsed_window (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift_en,
	input  dsed_pkg::trio_t [2:0]  new_col,
	output dsed_pkg::plane_t       center_plane,
	output dsed_pkg::kind_t        kind
);

	// win_q[level][row][column]
	dsed_pkg::sample_t win_q [3][3][3];
	dsed_pkg::sample_t v;
	logic own_max, own_min, nb_max, nb_min;

	// Shift each row one column left and load the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 3; l++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						win_q[l][r][c] <= '0;
					end
				end
			end
		end else if (shift_en) begin
			for (int l = 0; l < 3; l++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[l][r][0] <= win_q[l][r][1];
					win_q[l][r][1] <= win_q[l][r][2];
					win_q[l][r][2] <= new_col[l][r];
				end
			end
		end
	end

	// Current level plane for the edge test.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				center_plane[r][c] = win_q[1][r][c];
			end
		end
	end

	// Ties count: the center must be no smaller (larger) than every neighbor.
	always_comb begin
		v = win_q[1][1][1];
		own_max = 1'b1;
		own_min = 1'b1;
		nb_max = 1'b1;
		nb_min = 1'b1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				own_max &= ($signed(v) >= $signed(win_q[1][r][c]));
				own_min &= ($signed(v) <= $signed(win_q[1][r][c]));
				nb_max &= ($signed(v) >= $signed(win_q[0][r][c]))
					&& ($signed(v) >= $signed(win_q[2][r][c]));
				nb_min &= ($signed(v) <= $signed(win_q[0][r][c]))
					&& ($signed(v) <= $signed(win_q[2][r][c]));
			end
		end
		// The max test takes precedence over the min test.
		priority if (own_max) begin
			kind = nb_max ? dsed_pkg::KIND_MAX : dsed_pkg::KIND_NONE;
		end else if (own_min) begin
			kind = nb_min ? dsed_pkg::KIND_MIN : dsed_pkg::KIND_NONE;
		end else begin
			kind = dsed_pkg::KIND_NONE;
		end
	end

endmodule

/* rtl/dsed_edge.sv */
// Three-stage edge test on the 2x2 Hessian of the current level.
`timescale 1ns / 1ps
module dsed_edge (
	input  logic             clk,
	input  dsed_pkg::plane_t c,
	input  logic [5:0]       ratio,
	output logic             on_edge
);

	localparam int SB = dsed_pkg::SAMPLE_BITS;
	localparam int DW = SB + 2;
	localparam int TW = SB + 3;
	localparam int LW = 2 * TW + 10;
	localparam int AW = 2 * DW + 4;
	localparam int RW = AW + 1 + 13;

	logic signed [DW-1:0] dxx, dyy, dxy4;
	logic signed [TW-1:0] tr;
	logic [DW-1:0] pxx, pyy, pxy;
	logic [TW-1:0] ptr;
	logic [6:0] r1;
	logic [AW-1:0] a2;

	logic [2*TW-1:0] tr2_s1;
	logic [2*DW-1:0] pp_s1, bb_s1;
	logic aneg_s1;
	logic [12:0] rr_s1;
	logic [5:0] r_s1;

	logic [LW-1:0] lhs_s2, lhs_s3;
	logic [AW:0] d_s2;
	logic [12:0] rr_s2;
	logic [RW-1:0] rhs_s3;

	// Central differences; the mixed term is kept times four.
	always_comb begin
		dxx = DW'(c[1][2]) - (DW'(c[1][1]) <<< 1) + DW'(c[1][0]);
		dyy = DW'(c[2][1]) - (DW'(c[1][1]) <<< 1) + DW'(c[0][1]);
		dxy4 = DW'(c[2][2]) - DW'(c[2][0]) - DW'(c[0][2]) + DW'(c[0][0]);
		tr = TW'(dxx) + TW'(dyy);
		pxx = dxx[DW-1] ? DW'(-dxx) : DW'(dxx);
		pyy = dyy[DW-1] ? DW'(-dyy) : DW'(dyy);
		pxy = dxy4[DW-1] ? DW'(-dxy4) : DW'(dxy4);
		ptr = tr[TW-1] ? TW'(-tr) : TW'(tr);
		r1 = {1'b0, ratio} + 7'd1;
	end

	// Stage 1: squares and products of the differences.
	always_ff @(posedge clk) begin
		tr2_s1 <= ptr * ptr;
		pp_s1 <= pxx * pyy;
		bb_s1 <= pxy * pxy;
		aneg_s1 <= (dxx[DW-1] != dyy[DW-1]) && (pxx != '0) && (pyy != '0);
		rr_s1 <= 13'(r1 * r1);
		r_s1 <= ratio;
	end

	// Stage 2: trace side and absolute determinant, both scaled by 16.
	always_comb begin
		a2 = {pp_s1, 4'b0000};
	end

	always_ff @(posedge clk) begin
		lhs_s2 <= {(LW - 4)'((LW - 4)'(tr2_s1) * r_s1), 4'b0000};
		if (aneg_s1) begin
			d_s2 <= (AW + 1)'(a2) + (AW + 1)'(bb_s1);
		end else if (a2 >= AW'(bb_s1)) begin
			d_s2 <= (AW + 1)'(a2 - AW'(bb_s1));
		end else begin
			d_s2 <= (AW + 1)'(AW'(bb_s1) - a2);
		end
		rr_s2 <= rr_s1;
	end

	// Stage 3: (r+1)^2 times the determinant.
	always_ff @(posedge clk) begin
		rhs_s3 <= RW'(rr_s2) * RW'(d_s2);
		lhs_s3 <= lhs_s2;
	end

	assign on_edge = RW'(lhs_s3) >= rhs_s3;

endmodule

/* rtl/dog_scale_space_extremum_detect.sv */
// Top level of the difference-of-Gaussian 3x3x3 extremum detector.
`timescale 1ns / 1ps
// Usage:
//   pix_valid/pix_ready/pix carries one raster pixel with its lower, current
//   and upper level samples. res_valid/res_ready/res returns one result per
//   pixel, for the window center one row up and one column left.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes the five registers; write
//   only while no pixel is in flight. cfg_ready is always high.
// Timing:
//   A pixel transfer starts a sequence: line memory read, window
//   shift with memory write back, the edge-test multiply stages s1 to s3 and a
//   result stage. The result is registered at the end of this sequence,
//   and a new pixel is taken only after the result has entered the output
//   register. The multiply chain of the edge test sets the sequence length.
//   Each line memory entry is read and written back before the next pixel
//   is taken, so no forwarding is needed.
// Reset:
//   Counters, window and registers return to their defaults at once; there is
//   no clearing pass, the line memory holds stale data until written.
// Stall:
//   While res_ready is low a result waits in the output register; the next
//   result is then held back in the done state and no further pixel is taken.
module dog_scale_space_extremum_detect #(
	parameter int MAX_WIDTH = dsed_pkg::DEF_MAX_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_ready,
	input  dsed_pkg::pixel_t                     pix,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output dsed_pkg::result_t                    res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dsed_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dsed_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int SB = dsed_pkg::SAMPLE_BITS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
	localparam int MEM_W = 6 * SB;

	typedef logic [1:0][2:0][SB-1:0] line_t;

	dsed_pkg::state_t state_q, state_nx;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [7:0]  border_q;
	logic [14:0] thres_q;
	logic [5:0]  ratio_q;

	logic [CW-1:0] col_q, colp_q, col_eff;
	logic [11:0]   row_q, rowp_q, row_eff;
	logic [12:0]   row_tmp;
	logic          par_q;
	dsed_pkg::pixel_t samp_q;

	logic [WW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic [7:0]    b_eff;

	logic accept, shift_en, load_res, wrap_col;
	line_t rd_line, wr_line;
	dsed_pkg::trio_t [2:0] new_col;
	dsed_pkg::plane_t center_plane;
	dsed_pkg::kind_t  win_kind, kind_fin;
	logic on_edge, in_border, low_contrast, centre_ok;
	logic [CW-1:0] cx;
	logic [11:0]   cy;
	logic [SB-1:0] vmag;

	assign cfg_ready = 1'b1;
	assign pix_ready = (state_q == dsed_pkg::ST_IDLE);
	assign accept = pix_valid && pix_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640;
			height_q <= 13'd480;
			border_q <= 8'd1;
			thres_q <= '0;
			ratio_q <= 6'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dsed_pkg::REG_IMAGE_WIDTH:    width_q <= cfg_data[10:0];
				dsed_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data[12:0];
				dsed_pkg::REG_BORDER_WIDTH:   border_q <= cfg_data[7:0];
				dsed_pkg::REG_CONTRAST_THRES: thres_q <= cfg_data;
				dsed_pkg::REG_EDGE_RATIO:     ratio_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Clamped image size and position of the incoming pixel.
	always_comb begin
		if (width_q < 11'd3) begin
			w_eff = WW'(3);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < 13'd3) begin
			h_eff = 13'd3;
		end else if (height_q > 13'(dsed_pkg::MAX_HEIGHT)) begin
			h_eff = 13'(dsed_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		b_eff = (border_q == 8'd0) ? 8'd1 : border_q;
		wrap_col = WW'(col_q) >= w_eff;
		col_eff = wrap_col ? '0 : col_q;
		row_tmp = wrap_col ? {1'b0, row_q} + 13'd1 : {1'b0, row_q};
		row_eff = (row_tmp >= h_eff) ? '0 : row_tmp[11:0];
	end

	// Pixel counters and the captured pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (WW'(col_eff) + WW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= ({1'b0, row_eff} + 13'd1 >= h_eff) ? '0 : row_eff + 12'd1;
			end else begin
				col_q <= col_eff + CW'(1);
				row_q <= row_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= pix;
			colp_q <= col_eff;
			rowp_q <= row_eff;
			par_q <= row_eff[0];
		end
	end

	// Read the two stored rows, put the new sample in the current row's bank.
	always_comb begin
		wr_line = rd_line;
		for (int l = 0; l < 3; l++) begin
			new_col[l][0] = rd_line[par_q][l];
			new_col[l][1] = rd_line[~par_q][l];
		end
		new_col[0][2] = samp_q.lower_sample;
		new_col[1][2] = samp_q.center_sample;
		new_col[2][2] = samp_q.upper_sample;
		wr_line[par_q][0] = samp_q.lower_sample;
		wr_line[par_q][1] = samp_q.center_sample;
		wr_line[par_q][2] = samp_q.upper_sample;
	end

	dsed_line_mem #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(MEM_W)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(col_eff),
		.rd_data(rd_line),
		.wr_en  (shift_en),
		.wr_addr(colp_q),
		.wr_data(wr_line)
	);

	dsed_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift_en    (shift_en),
		.new_col     (new_col),
		.center_plane(center_plane),
		.kind        (win_kind)
	);

	dsed_edge u_edge (
		.clk    (clk),
		.c      (center_plane),
		.ratio  (ratio_q),
		.on_edge(on_edge)
	);

	// Border, contrast and edge rejection of the window center.
	always_comb begin
		cx = colp_q - CW'(1);
		cy = rowp_q - 12'd1;
		in_border = ((WW + 1)'(cx) < (WW + 1)'(b_eff))
			|| ((WW + 1)'(cx) + (WW + 1)'(b_eff) >= (WW + 1)'(w_eff))
			|| (cy < 12'(b_eff))
			|| (13'(cy) + 13'(b_eff) >= h_eff);
		vmag = center_plane[1][1][SB-1] ? SB'(-center_plane[1][1])
			: SB'(center_plane[1][1]);
		low_contrast = vmag < SB'(thres_q);
		centre_ok = (colp_q != '0) && (rowp_q != '0);
		if (in_border || low_contrast || on_edge) begin
			kind_fin = dsed_pkg::KIND_NONE;
		end else begin
			kind_fin = win_kind;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsed_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		shift_en = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			dsed_pkg::ST_IDLE: begin
				if (accept) begin
					state_nx = dsed_pkg::ST_WIN;
				end
			end
			dsed_pkg::ST_WIN: begin
				shift_en = 1'b1;
				state_nx = dsed_pkg::ST_P1;
			end
			dsed_pkg::ST_P1: state_nx = dsed_pkg::ST_P2;
			dsed_pkg::ST_P2: state_nx = dsed_pkg::ST_P3;
			dsed_pkg::ST_P3: state_nx = dsed_pkg::ST_DONE;
			dsed_pkg::ST_DONE: begin
				if (!res_valid || res_ready) begin
					load_res = 1'b1;
					state_nx = dsed_pkg::ST_IDLE;
				end
			end
			default: state_nx = dsed_pkg::ST_IDLE;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load_res) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			if (centre_ok) begin
				res.out_valid <= 1'b1;
				res.pos_x <= 10'(cx);
				res.pos_y <= cy;
				res.extremum_kind <= kind_fin;
				res.center_value <= center_plane[1][1];
			end else begin
				res <= '0;
			end
		end
	end

	// One pixel at a time: a transfer is followed by the window step.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == dsed_pkg::ST_WIN) && !pix_ready)
		else $error("pixel taken while another is in flight");

	// A class is only reported for a real window center.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.extremum_kind != dsed_pkg::KIND_NONE) |-> res.out_valid)
		else $error("class reported without a valid center");

	// A new result is loaded only when the previous one has been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!res_valid || res_ready))
		else $error("pending result overwritten");

endmodule
